FILE: src/abarc_pkg.sv
// Shared types and constants for the ADC block average / range check.
// No dependencies; compiled first.
package abarc_pkg;

  // Field widths
  localparam int CH_W   = 4;
  localparam int SMP_W  = 12;
  localparam int SUM_W  = 16;
  localparam int MASK_W = 16;
  localparam int CHK_W  = 5;

  // Configuration port
  localparam int REG_W = 12;
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [IDX_W-1:0] REG_CHECKED    = 2'd2;

  // Register reset values
  localparam logic [SMP_W-1:0] RANGE_LOW_RST  = 12'd10;
  localparam logic [SMP_W-1:0] RANGE_HIGH_RST = 12'd4000;
  localparam logic [CHK_W-1:0] CHECKED_RST    = 5'd10;

  // Saturation limits
  localparam logic [SUM_W-1:0] SUM_MAX = 16'hFFFF;
  localparam logic [SMP_W-1:0] AVG_MAX = 12'hFFF;

  // Parameter defaults
  localparam int SCANS_DEF    = 8;
  localparam int CHANNELS_DEF = 16;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             acc_en;   // add sample into the matching cell
    logic             shift;    // move every sum one cell toward the head
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
  } cell_ctl_t;

endpackage

FILE: src/abarc_if.sv
// Stream interfaces for samples in and averaged results out.
// Depends on abarc_pkg.
interface abarc_sample_if;
  import abarc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SMP_W-1:0] sample;
  logic             scan_done;

  modport source(output valid, channel, sample, scan_done, input ready);
  modport sink(input valid, channel, sample, scan_done, output ready);
endinterface

interface abarc_result_if;
  import abarc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_channel;
  logic [SMP_W-1:0]  average;
  logic              out_of_range;
  logic [MASK_W-1:0] fault_mask;
  logic              last;

  modport source(output valid, out_channel, average, out_of_range, fault_mask, last,
                 input ready);
  modport sink(input valid, out_channel, average, out_of_range, fault_mask, last,
               output ready);
endinterface

FILE: src/adc_block_average_range_check.sv
// Top level: per-channel block averaging with range fault flags.
// Depends on abarc_pkg, abarc_if, abarc_cell, abarc_avg.
//
//   port      | dir | handshake   | transaction
//   ----------+-----+-------------+---------------------------------------
//   samples   | in  | valid/ready | channel, sample, scan_done
//   results   | out | valid/ready | out_channel, average, out_of_range,
//             |     |             | fault_mask, last
//   wr_*      | in  | wr_en only  | register index, data
//
// Samples are taken one per cycle while accumulating. The sample that ends
// the SCANS-th scan starts a drain: the cell chain shifts one sum per result
// into the divider, in two steps per result (multiply, then correct/check);
// an output stall lengthens the drain, and samples wait meanwhile.
// The output register holds a result until taken and only stalls the drain.
// Reset (rst, synchronous) clears sums, scan count and valid, and loads the registers' reset values.
module adc_block_average_range_check #(
  parameter int SCANS    = abarc_pkg::SCANS_DEF,
  parameter int CHANNELS = abarc_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [abarc_pkg::IDX_W-1:0] wr_index,
  input  logic [abarc_pkg::REG_W-1:0] wr_data,
  abarc_sample_if.sink                samples,
  abarc_result_if.source              results
);
  import abarc_pkg::*;

  localparam int CW = $clog2(SCANS + 1);
  localparam int KW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] ST_ACC = 2'd0;
  localparam logic [1:0] ST_MUL = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     scan_count;
  logic [KW-1:0]     k;
  logic [MASK_W-1:0] fault;
  logic [MASK_W-1:0] fault_next;
  logic [SMP_W-1:0]  range_low;
  logic [SMP_W-1:0]  range_high;
  logic [CHK_W-1:0]  checked_channels;
  logic              accept;
  logic              out_free;
  logic              k_last;
  cell_ctl_t         ctl;
  logic [SUM_W-1:0]  sums [CHANNELS+1];
  logic [SMP_W-1:0]  avg;
  logic              bad;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low        <= RANGE_LOW_RST;
      range_high       <= RANGE_HIGH_RST;
      checked_channels <= CHECKED_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RANGE_LOW:  range_low        <= wr_data[SMP_W-1:0];
        REG_RANGE_HIGH: range_high       <= wr_data[SMP_W-1:0];
        REG_CHECKED:    checked_channels <= wr_data[CHK_W-1:0];
        default: ;
      endcase
    end
  end

  assign samples.ready = (state == ST_ACC);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;
  assign k_last        = (k == KW'(CHANNELS - 1));

  // Broadcast to the cell chain
  always_comb begin
    ctl.acc_en  = accept;
    ctl.shift   = (state == ST_MUL);
    ctl.channel = samples.channel;
    ctl.sample  = samples.sample;
  end

  // Cell chain; head is cell 0, zeros enter at the tail
  assign sums[CHANNELS] = '0;
  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    abarc_cell #(.INDEX(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .nb_sum (sums[i+1]),
      .sum    (sums[i])
    );
  end

  abarc_avg #(.SCANS(SCANS)) u_avg (
    .clk        (clk),
    .load       (ctl.shift),
    .sum        (sums[0]),
    .range_low  (range_low),
    .range_high (range_high),
    .checked    (CHK_W'(k) < checked_channels),
    .avg        (avg),
    .bad        (bad)
  );

  assign fault_next = fault | (MASK_W'(bad) << k);

  // Sequencer: accumulate, then drain one channel per multiply/finish pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACC;
      scan_count <= '0;
      k          <= '0;
      fault      <= '0;
    end else begin
      unique case (state)
        ST_ACC: begin
          if (accept && samples.scan_done) begin
            if (scan_count == CW'(SCANS - 1)) begin
              scan_count <= '0;
              k          <= '0;
              fault      <= '0;
              state      <= ST_MUL;
            end else begin
              scan_count <= scan_count + 1'b1;
            end
          end
        end
        ST_MUL: state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            fault <= fault_next;
            if (k_last) begin
              state <= ST_ACC;
            end else begin
              k     <= k + 1'b1;
              state <= ST_MUL;
            end
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      results.out_channel  <= CH_W'(k);
      results.average      <= avg;
      results.out_of_range <= bad;
      results.fault_mask   <= k_last ? fault_next : '0;
      results.last         <= k_last;
    end
  end

endmodule

FILE: src/abarc_cell.sv
// One accumulator cell of the channel chain: saturating add or shift from neighbor.
// Depends on abarc_pkg.
module abarc_cell #(
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  abarc_pkg::cell_ctl_t         ctl,
  input  logic [abarc_pkg::SUM_W-1:0]  nb_sum,
  output logic [abarc_pkg::SUM_W-1:0]  sum
);
  import abarc_pkg::*;

  logic [SUM_W:0]   add_wide;
  logic [SUM_W-1:0] add_sat;

  // Saturating add of the broadcast sample
  assign add_wide = {1'b0, sum} + (SUM_W+1)'(ctl.sample);
  assign add_sat  = add_wide[SUM_W] ? SUM_MAX : add_wide[SUM_W-1:0];

  // Shift during drain clears the chain from the tail
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.shift) begin
      sum <= nb_sum;
    end else if (ctl.acc_en && ctl.channel == CH_W'(INDEX)) begin
      sum <= add_sat;
    end
  end

endmodule

FILE: src/abarc_avg.sv
// Divide-by-SCANS unit with range check; reciprocal multiply, then correction.
// Depends on abarc_pkg.
module abarc_avg #(
  parameter int SCANS = abarc_pkg::SCANS_DEF
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [abarc_pkg::SUM_W-1:0] sum,
  input  logic [abarc_pkg::SMP_W-1:0] range_low,
  input  logic [abarc_pkg::SMP_W-1:0] range_high,
  input  logic                        checked,
  output logic [abarc_pkg::SMP_W-1:0] avg,
  output logic                        bad
);
  import abarc_pkg::*;

  localparam int RSH = 20;
  localparam logic [RSH:0] RECIP = (RSH+1)'((1 << RSH) / SCANS);

  logic [SUM_W+RSH:0] prod;
  logic [SUM_W-1:0]   sum_hold;
  logic [SUM_W-1:0]   q0;
  logic [SUM_W-1:0]   q;
  logic [SUM_W:0]     qs;
  logic [SUM_W:0]     rem;

  // Multiply stage: estimate is the true quotient or one below it
  always_ff @(posedge clk) begin
    if (load) begin
      prod     <= (SUM_W+RSH+1)'(sum) * (SUM_W+RSH+1)'(RECIP);
      sum_hold <= sum;
    end
  end

  // Correction, saturation, threshold check
  always_comb begin
    q0  = prod[SUM_W+RSH-1:RSH];
    qs  = (SUM_W+1)'((SUM_W+6)'(q0) * (SUM_W+6)'(SCANS));
    rem = (SUM_W+1)'(sum_hold) - qs;
    q   = (rem >= (SUM_W+1)'(SCANS)) ? q0 + 1'b1 : q0;
    avg = (q > SUM_W'(AVG_MAX)) ? AVG_MAX : q[SMP_W-1:0];
    bad = checked && ((avg < range_low) || (avg > range_high));
  end

endmodule

FILE: src/abarc_check.sv
// Port-level checker for adc_block_average_range_check, attached by bind.
// Depends on abarc_pkg and the top level's ports.
module abarc_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [abarc_pkg::SMP_W-1:0]  out_average,
  input logic [abarc_pkg::MASK_W-1:0] out_fault_mask,
  input logic                         out_last
);
  import abarc_pkg::*;

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // No sample is taken while a batch is still draining
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("sample ready during drain");

  // Only the final result carries the mask
  a_mask_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_fault_mask == '0)
    else $error("fault mask on non-final result");

  // A stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_average))
    else $error("stalled result changed");

endmodule

bind adc_block_average_range_check abarc_check u_abarc_check (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (samples.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_average    (results.average),
  .out_fault_mask (results.fault_mask),
  .out_last       (results.last)
);
